@@ rtl/core/asp_pkg.sv @@
`timescale 1ns / 1ps

package asp_pkg;

  // Default position word width
  localparam int POSITION_BITS_DEF = 10;

  // Fixed config field widths
  localparam int BAND_W  = 10;
  localparam int GAIN_W  = 16;
  localparam int SPEED_W = 15;
  localparam int CMD_W   = 16;

  // Filter fraction bits and alpha 0.15 in Q0.16
  localparam int              FRAC_BITS = 8;
  localparam logic signed [15:0] ALPHA_Q16 = 16'sd9830;

  // Drive deadzone, 0.08 in Q1.15
  localparam logic [16:0] DEADZONE_Q15 = 17'd2622;

  // Full reverse command and its fixed duty bytes (duty 0.01)
  localparam logic [CMD_W-1:0] CMD_FULL_REV = 16'h8000;
  localparam logic [7:0]       FULL_REV_FWD = 8'd2;
  localparam logic [7:0]       FULL_REV_REV = 8'd252;

  // Register reset values
  localparam logic [BAND_W-1:0]  RST_STOP_ENTER = 10'd10;
  localparam logic [BAND_W-1:0]  RST_STOP_EXIT  = 10'd25;
  localparam logic [BAND_W-1:0]  RST_NEAR_BAND  = 10'd60;
  localparam logic [BAND_W-1:0]  RST_LOWER_LIM  = 10'd405;
  localparam logic [BAND_W-1:0]  RST_UPPER_LIM  = 10'd640;
  localparam logic [GAIN_W-1:0]  RST_GAIN_FAR   = 16'd524;
  localparam logic [GAIN_W-1:0]  RST_GAIN_NEAR  = 16'd262;
  localparam logic [SPEED_W-1:0] RST_SPEED_CAP  = 15'd11469;

  // APB register map, one word per register
  localparam int REG_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_STOP_ENTER = 3'd0,
    REG_STOP_EXIT  = 3'd1,
    REG_NEAR_BAND  = 3'd2,
    REG_LOWER_LIM  = 3'd3,
    REG_UPPER_LIM  = 3'd4,
    REG_GAIN_FAR   = 3'd5,
    REG_GAIN_NEAR  = 3'd6,
    REG_SPEED_CAP  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [BAND_W-1:0]  stop_enter_band;
    logic [BAND_W-1:0]  stop_exit_band;
    logic [BAND_W-1:0]  near_band;
    logic [BAND_W-1:0]  lower_limit;
    logic [BAND_W-1:0]  upper_limit;
    logic [GAIN_W-1:0]  gain_far;
    logic [GAIN_W-1:0]  gain_near;
    logic [SPEED_W-1:0] speed_cap;
  } cfg_t;

  // Control bits leaving the tracking stage
  typedef struct packed {
    logic manual;   // item is a stick command
    logic neg;      // position below target
    logic far;      // error beyond near range
    logic stop;     // held at target, no drive
    logic holding;  // is_holding for this item
  } trk_ctl_t;

  // Control bits leaving the gain stage
  typedef struct packed {
    logic stop;
    logic holding;
  } cmd_ctl_t;

endpackage

@@ rtl/core/asp_track.sv @@
`timescale 1ns / 1ps

module asp_track import asp_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  cfg_t                     cfg,
  input  logic                     op,
  input  logic [POSITION_BITS-1:0] sample,
  input  logic [POSITION_BITS-1:0] target,
  input  logic signed [CMD_W-1:0]  manual,
  output logic [POSITION_BITS-1:0] pos_q,
  output logic [POSITION_BITS-1:0] aerr_q,
  output trk_ctl_t                 ctl_q,
  output logic signed [CMD_W-1:0]  manual_q
);

  localparam int FW    = POSITION_BITS + FRAC_BITS;
  localparam int PW    = FW + 17;
  localparam int CMP_W = (POSITION_BITS > BAND_W) ? POSITION_BITS : BAND_W;

  // Filter and hysteresis state
  logic [FW-1:0]            filt;
  logic                     seeded;
  logic [POSITION_BITS-1:0] prev_target;
  logic                     holding_flag;

  logic [FW-1:0]            filt_next;
  logic                     holding_next;
  logic [FW-1:0]            s_ext;
  logic [FW-1:0]            f_cur;
  logic signed [FW:0]       diff;
  logic signed [PW-1:0]     prod;
  logic signed [PW-1:0]     acc;
  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] aerr;
  logic                     neg;
  logic [CMP_W-1:0]         aerr_x;
  logic                     hold_in;
  logic                     stop;
  trk_ctl_t                 ctl;

  // f' = f - (f - s)*alpha, same floor as f*(1-alpha) + s*alpha
  always_comb begin
    s_ext     = {sample, {FRAC_BITS{1'b0}}};
    f_cur     = seeded ? filt : s_ext;
    diff      = $signed({1'b0, f_cur}) - $signed({1'b0, s_ext});
    prod      = PW'(diff) * PW'(ALPHA_Q16);
    acc       = $signed({1'b0, f_cur, 16'b0}) - prod;
    filt_next = acc[FW+15:16];
    pos       = filt_next[FW-1:FRAC_BITS];
  end

  always_comb begin
    neg     = pos < target;
    aerr    = neg ? (target - pos) : (pos - target);
    aerr_x  = CMP_W'(aerr);
    hold_in = holding_flag && (target == prev_target);
    if (hold_in && (aerr_x <= CMP_W'(cfg.stop_exit_band))) begin
      stop = 1'b1;
    end else if (aerr_x <= CMP_W'(cfg.stop_enter_band)) begin
      stop = 1'b1;
    end else begin
      stop = 1'b0;
    end
    holding_next = stop;
  end

  always_comb begin
    ctl.manual  = op;
    ctl.neg     = op ? 1'b0 : neg;
    ctl.far     = aerr_x > CMP_W'(cfg.near_band);
    ctl.stop    = op ? 1'b0 : stop;
    ctl.holding = op ? 1'b0 : stop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt         <= '0;
      seeded       <= 1'b0;
      prev_target  <= '0;
      holding_flag <= 1'b0;
    end else if (en && !op) begin
      filt         <= filt_next;
      seeded       <= 1'b1;
      prev_target  <= target;
      holding_flag <= holding_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_q    <= op ? sample : pos;
      aerr_q   <= aerr;
      ctl_q    <= ctl;
      manual_q <= manual;
    end
  end

endmodule

@@ rtl/core/asp_gain.sv @@
`timescale 1ns / 1ps

module asp_gain import asp_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  cfg_t                     cfg,
  input  logic [POSITION_BITS-1:0] pos,
  input  logic [POSITION_BITS-1:0] aerr,
  input  trk_ctl_t                 ctl,
  input  logic signed [CMD_W-1:0]  manual,
  output logic [POSITION_BITS-1:0] pos_q,
  output logic signed [CMD_W-1:0]  cmd_q,
  output cmd_ctl_t                 ctl_q
);

  localparam int MW = GAIN_W + POSITION_BITS;

  logic [GAIN_W-1:0]        gain;
  logic [MW-1:0]            prod;
  logic [MW-2:0]            mag_full;
  logic [SPEED_W-1:0]       mag;
  logic [CMD_W-1:0]         mag16;
  logic signed [CMD_W-1:0]  cmd;
  cmd_ctl_t                 ctl_out;

  always_comb begin
    gain     = ctl.far ? cfg.gain_far : cfg.gain_near;
    prod     = MW'(gain) * MW'(aerr);
    mag_full = prod[MW-1:1];
    if (mag_full > (MW-1)'(cfg.speed_cap)) begin
      mag = cfg.speed_cap;
    end else begin
      mag = mag_full[SPEED_W-1:0];
    end
    mag16 = {1'b0, mag};
    if (ctl.manual) begin
      cmd = manual;
    end else if (ctl.neg) begin
      cmd = $signed(~mag16 + 16'd1);
    end else begin
      cmd = $signed(mag16);
    end
    ctl_out.stop    = ctl.stop;
    ctl_out.holding = ctl.holding;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_q <= pos;
      cmd_q <= cmd;
      ctl_q <= ctl_out;
    end
  end

endmodule

@@ rtl/core/asp_drive.sv @@
`timescale 1ns / 1ps

module asp_drive import asp_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  cfg_t                     cfg,
  input  logic [POSITION_BITS-1:0] pos,
  input  logic signed [CMD_W-1:0]  cmd,
  input  cmd_ctl_t                 ctl,
  output logic [7:0]               fwd_q,
  output logic [7:0]               rev_q,
  output logic                     holding_q,
  output logic                     limit_q,
  output logic [POSITION_BITS-1:0] pos_q
);

  localparam int CMP_W = (POSITION_BITS > BAND_W) ? POSITION_BITS : BAND_W;

  logic              neg;
  logic [16:0]       amag;
  logic [CMP_W-1:0]  pos_x;
  logic [15:0]       duty;
  logic [16:0]       inv;
  logic [23:0]       fprod;
  logic [23:0]       rprod;
  logic [7:0]        fwd;
  logic [7:0]        rev;
  logic              limit;

  always_comb begin
    neg   = cmd[CMD_W-1];
    amag  = neg ? (17'd0 - {cmd[CMD_W-1], cmd}) : {1'b0, cmd};
    pos_x = CMP_W'(pos);
    // duty = cmd + 0.5 full scale; *255 as shift minus one copy
    duty  = {~cmd[CMD_W-1], cmd[CMD_W-2:0]};
    inv   = 17'h10000 - {1'b0, duty};
    fprod = {duty, 8'b0} - 24'(duty);
    rprod = 24'({inv, 8'b0}) - 24'(inv);
    fwd   = 8'd0;
    rev   = 8'd0;
    limit = 1'b0;
    if (ctl.stop || (amag < DEADZONE_Q15)) begin
      limit = 1'b0;
    end else if ((pos_x < CMP_W'(cfg.lower_limit)) && !neg) begin
      limit = 1'b1;
    end else if ((pos_x > CMP_W'(cfg.upper_limit)) && neg) begin
      limit = 1'b1;
    end else if (cmd == CMD_FULL_REV) begin
      fwd = FULL_REV_FWD;
      rev = FULL_REV_REV;
    end else begin
      fwd = fprod[23:16];
      rev = rprod[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fwd_q     <= fwd;
      rev_q     <= rev;
      holding_q <= ctl.holding;
      limit_q   <= limit;
      pos_q     <= pos;
    end
  end

endmodule

@@ rtl/core/arm_position_servo.sv @@
`timescale 1ns / 1ps
// Arm position servo: filtered position tracking with hold hysteresis and a shared drive stage.
// Items pass through the input, track, gain and drive registers in order; out_ready can stall.
// Throughput: one item per cycle unless stalled; filter and hold close their loop in one stage.
// Reset (rst, synchronous): pipeline empty, filter unseeded, hold cleared, registers to defaults.
module arm_position_servo import asp_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // Item input channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     op,
  input  logic [POSITION_BITS-1:0] position_sample,
  input  logic [POSITION_BITS-1:0] target_position,
  input  logic signed [CMD_W-1:0]  manual_command,
  // Result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               drive_forward_duty,
  output logic [7:0]               drive_reverse_duty,
  output logic                     is_holding,
  output logic                     limit_stopped,
  output logic [POSITION_BITS-1:0] filtered_position,
  // APB config port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [REG_ADDR_W-1:0]    paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  // ---------------------------------------------------------------------
  // Config registers. The user is to write them only while the servo is idle; the block does not enforce it.
  // ---------------------------------------------------------------------
  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[REG_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stop_enter_band <= RST_STOP_ENTER;
      cfg.stop_exit_band  <= RST_STOP_EXIT;
      cfg.near_band       <= RST_NEAR_BAND;
      cfg.lower_limit     <= RST_LOWER_LIM;
      cfg.upper_limit     <= RST_UPPER_LIM;
      cfg.gain_far        <= RST_GAIN_FAR;
      cfg.gain_near       <= RST_GAIN_NEAR;
      cfg.speed_cap       <= RST_SPEED_CAP;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_STOP_ENTER: cfg.stop_enter_band <= pwdata[BAND_W-1:0];
        REG_STOP_EXIT:  cfg.stop_exit_band  <= pwdata[BAND_W-1:0];
        REG_NEAR_BAND:  cfg.near_band       <= pwdata[BAND_W-1:0];
        REG_LOWER_LIM:  cfg.lower_limit     <= pwdata[BAND_W-1:0];
        REG_UPPER_LIM:  cfg.upper_limit     <= pwdata[BAND_W-1:0];
        REG_GAIN_FAR:   cfg.gain_far        <= pwdata[GAIN_W-1:0];
        REG_GAIN_NEAR:  cfg.gain_near       <= pwdata[GAIN_W-1:0];
        REG_SPEED_CAP:  cfg.speed_cap       <= pwdata[SPEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_STOP_ENTER: prdata = 32'(cfg.stop_enter_band);
      REG_STOP_EXIT:  prdata = 32'(cfg.stop_exit_band);
      REG_NEAR_BAND:  prdata = 32'(cfg.near_band);
      REG_LOWER_LIM:  prdata = 32'(cfg.lower_limit);
      REG_UPPER_LIM:  prdata = 32'(cfg.upper_limit);
      REG_GAIN_FAR:   prdata = 32'(cfg.gain_far);
      REG_GAIN_NEAR:  prdata = 32'(cfg.gain_near);
      REG_SPEED_CAP:  prdata = 32'(cfg.speed_cap);
      default:        prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline control. Four register stages:
  //   v0 input register -> v1 track (filter, hold) -> v2 gain -> v3 output
  // A stage loads when it is empty or the stage below it moves on, so
  // bubbles collapse and a stalled output still lets items queue up.
  // The track stage only updates its state on a real item that is not a stick command.
  // ---------------------------------------------------------------------
  logic v0, v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  logic en1, en2, en3;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = !v0 || rdy1;
  assign en1      = v0 && rdy1;
  assign en2      = v1 && rdy2;
  assign en3      = v2 && rdy3;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (in_ready) begin
        v0 <= in_valid;
      end
      if (rdy1) begin
        v1 <= v0;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  // Input register: payload only, no reset
  logic                     op_q;
  logic [POSITION_BITS-1:0] sample_q;
  logic [POSITION_BITS-1:0] target_q;
  logic signed [CMD_W-1:0]  manual_q;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q     <= op;
      sample_q <= position_sample;
      target_q <= target_position;
      manual_q <= manual_command;
    end
  end

  // Track stage: low-pass filter, error, hold hysteresis
  logic [POSITION_BITS-1:0] t_pos;
  logic [POSITION_BITS-1:0] t_aerr;
  trk_ctl_t                 t_ctl;
  logic signed [CMD_W-1:0]  t_manual;

  asp_track #(
    .POSITION_BITS (POSITION_BITS)
  ) u_track (
    .clk      (clk),
    .rst      (rst),
    .en       (en1),
    .cfg      (cfg),
    .op       (op_q),
    .sample   (sample_q),
    .target   (target_q),
    .manual   (manual_q),
    .pos_q    (t_pos),
    .aerr_q   (t_aerr),
    .ctl_q    (t_ctl),
    .manual_q (t_manual)
  );

  // Gain stage: proportional command, clamped to max speed; a stick command passes through unchanged
  logic [POSITION_BITS-1:0] g_pos;
  logic signed [CMD_W-1:0]  g_cmd;
  cmd_ctl_t                 g_ctl;

  asp_gain #(
    .POSITION_BITS (POSITION_BITS)
  ) u_gain (
    .clk    (clk),
    .en     (en2),
    .cfg    (cfg),
    .pos    (t_pos),
    .aerr   (t_aerr),
    .ctl    (t_ctl),
    .manual (t_manual),
    .pos_q  (g_pos),
    .cmd_q  (g_cmd),
    .ctl_q  (g_ctl)
  );

  // Drive stage: deadzone, travel limits, duty bytes; holds the output register
  asp_drive #(
    .POSITION_BITS (POSITION_BITS)
  ) u_drive (
    .clk       (clk),
    .en        (en3),
    .cfg       (cfg),
    .pos       (g_pos),
    .cmd       (g_cmd),
    .ctl       (g_ctl),
    .fwd_q     (drive_forward_duty),
    .rev_q     (drive_reverse_duty),
    .holding_q (is_holding),
    .limit_q   (limit_stopped),
    .pos_q     (filtered_position)
  );

endmodule
